### design/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on the rising clock edge outside reset
`define NND_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked on the rising clock edge outside reset
`define NND_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define NND_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define NND_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### design/nnd_pkg.sv
`default_nettype none

package nnd_pkg;

  // Fixed widths of the streams and the register port
  localparam int PIX_W       = 32;
  localparam int CFG_W       = 15;
  localparam int CFG_ADDR_W  = 2;

  // Defaults
  localparam int MAX_SOURCE_SIDE = 16384;
  localparam int LIMIT_RESET     = 1024;

  // Which quotient the shared divider works on
  typedef enum logic [1:0] {
    DIV_TW = 2'd0,  // target width
    DIV_TH = 2'd1,  // target height
    DIV_AX = 2'd2,  // source width / target width
    DIV_AY = 2'd3   // source height / target height
  } div_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic     hold;       // capture the accepted pixel
    logic     mul_en;     // load the product register
    logic     mul_h;      // product uses the height (else the width)
    logic     div_start;  // launch a division
    div_sel_t start_sel;
    logic     load;       // capture the finished quotient
    div_sel_t load_sel;
    logic     init_pos;   // restart output position and accumulators
    logic     step;       // evaluate one pixel
    logic     use_held;   // evaluate the captured pixel, not the bus
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic frame_start;
    logic out_free;
    logic div_done;
  } status_t;

endpackage

`default_nettype wire

### design/nearest_neighbor_downscale.sv
// Nearest-neighbor RGBA8 downscaler. A result beat is registered and appears in the
// cycle after the source pixel that selects it; the first pixel of a frame instead
// holds the input while one shared bit-serial divider works out the target size and
// the per-axis step. Throughput: otherwise one pixel per cycle while the output
// register can take a beat (out_tready back-pressure stalls the input).
// Reset: synchronous active-low; registers return to 1, 1, 1024, frame restarts.
`default_nettype none

`include "assert_macros.svh"

module nearest_neighbor_downscale #(
  parameter int MAX_SIDE = nnd_pkg::MAX_SOURCE_SIDE
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // register write port
  input  wire logic                           cfg_we,
  input  wire logic [nnd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [nnd_pkg::CFG_W-1:0]      cfg_wdata,
  // source pixels
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [nnd_pkg::PIX_W-1:0]      in_tdata,   // [31:0] in_pixel
  // downscaled pixels
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [nnd_pkg::PIX_W-1:0]           out_tdata,  // [31:0] out_pixel
  output logic                                out_tlast
);

  nnd_pkg::cmd_t    cmd;
  nnd_pkg::status_t status;

  nnd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  nnd_datapath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .status     (status)
  );

  // a pixel is only evaluated when the result register can take it
  `NND_ASSERT_IMP(a_step_room, clk, rst_n, cmd.step, status.out_free)
  // a mid-frame beat is evaluated in the cycle it is taken
  `NND_ASSERT_IMP(a_mid_step, clk, rst_n, in_tvalid && in_tready && !status.frame_start, cmd.step)
  // a frame-start beat stalls the input while setup runs
  `NND_ASSERT_NEXT(a_setup_stall, clk, rst_n, in_tvalid && in_tready && status.frame_start, !in_tready)
  // setup results are captured only from a finished division
  `NND_ASSERT_IMP(a_load_done, clk, rst_n, cmd.load, status.div_done)

endmodule

`default_nettype wire

### design/nnd_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle
module nnd_div #(
  parameter int NUM_W = 30,
  parameter int DEN_W = 15
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quo,
  output logic [DEN_W-1:0]      rem
);

  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic             last;

  // One shift-subtract step
  always_comb begin
    trial    = {rem_r, quo_r[NUM_W-1]};
    diff     = trial - {1'b0, den_r};
    ge       = trial >= {1'b0, den_r};
    last     = cnt_r == CNT_W'(NUM_W - 1);
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      cnt_nxt = cnt_r + CNT_W'(1);
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

### design/nnd_datapath.sv
`default_nettype none

// Registers, position counters, step accumulators, frame setup math and
// the output register.
module nnd_datapath #(
  parameter int MAX_SIDE = nnd_pkg::MAX_SOURCE_SIDE
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [nnd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [nnd_pkg::CFG_W-1:0]       cfg_wdata,
  input  wire logic [nnd_pkg::PIX_W-1:0]       in_tdata,
  input  wire logic                            out_tready,
  output logic                                 out_tvalid,
  output logic [nnd_pkg::PIX_W-1:0]            out_tdata,
  output logic                                 out_tlast,
  input  wire nnd_pkg::cmd_t                   cmd,
  output nnd_pkg::status_t                     status
);

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int POS_W  = $clog2(MAX_SIDE);
  localparam int CFG_W  = nnd_pkg::CFG_W;
  localparam int NUM_W  = SIDE_W + CFG_W;

  typedef enum logic [nnd_pkg::CFG_ADDR_W-1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_MAX_DIM    = 2'd2
  } reg_idx_t;

  // Size register as a side length: zero reads as one, clamp to the max
  function automatic logic [SIDE_W-1:0] side_of(input logic [CFG_W-1:0] v);
    if (v == '0) begin
      return SIDE_W'(1);
    end else if (32'(v) > 32'(MAX_SIDE)) begin
      return SIDE_W'(MAX_SIDE);
    end else begin
      return SIDE_W'(v);
    end
  endfunction

  logic [CFG_W-1:0]           src_width_r, src_width_nxt;
  logic [CFG_W-1:0]           src_height_r, src_height_nxt;
  logic [CFG_W-1:0]           max_dim_r, max_dim_nxt;
  logic                       cfg_hit;

  logic [SIDE_W-1:0]          w, h, big;
  logic [CFG_W-1:0]           lim;
  logic                       scale;

  logic [NUM_W-1:0]           mul_r;
  logic [SIDE_W-1:0]          mul_side;

  logic                       div_start;
  logic [NUM_W-1:0]           div_num;
  logic [SIDE_W-1:0]          div_den;
  logic                       div_done;
  logic [NUM_W-1:0]           div_quo;
  logic [SIDE_W-1:0]          div_rem;
  logic [SIDE_W-1:0]          quo_t;

  logic [SIDE_W-1:0]          tw_r, th_r, ax_r, bx_r, ay_r, by_r;

  logic [POS_W-1:0]           sc_r, sc_nxt, sr_r, sr_nxt;
  logic [POS_W:0]             sc_inc, sr_inc;
  logic [SIDE_W-1:0]          oc_r, oc_nxt, or_r, or_nxt, oc_inc;
  logic [SIDE_W-1:0]          col_q_r, col_q_nxt, col_r_r, col_r_nxt;
  logic [SIDE_W-1:0]          row_q_r, row_q_nxt, row_r_r, row_r_nxt;
  logic [SIDE_W:0]            csum, rsum;
  logic                       cwrap, rwrap;

  logic [nnd_pkg::PIX_W-1:0]  hold_r, pix;
  logic                       hit, emit, last;
  logic                       ov_r, ov_nxt;
  logic [nnd_pkg::PIX_W-1:0]  od_r;
  logic                       ol_r;

  // Register writes; any write to a known register restarts the frame
  always_comb begin
    src_width_nxt  = src_width_r;
    src_height_nxt = src_height_r;
    max_dim_nxt    = max_dim_r;
    cfg_hit        = 1'b0;
    if (cfg_we) begin
      case (cfg_addr)
        REG_SRC_WIDTH: begin
          src_width_nxt = cfg_wdata;
          cfg_hit       = 1'b1;
        end
        REG_SRC_HEIGHT: begin
          src_height_nxt = cfg_wdata;
          cfg_hit        = 1'b1;
        end
        REG_MAX_DIM: begin
          max_dim_nxt = cfg_wdata;
          cfg_hit     = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  // Effective sizes
  always_comb begin
    w     = side_of(src_width_r);
    h     = side_of(src_height_r);
    lim   = (max_dim_r == '0) ? CFG_W'(1) : max_dim_r;
    big   = (w > h) ? w : h;
    scale = 32'(big) > 32'(lim);
  end

  // Side times limit, one product per cycle
  assign mul_side = cmd.mul_h ? h : w;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      mul_r <= NUM_W'(mul_side) * NUM_W'(lim);
    end
  end

  // Divider operands
  always_comb begin
    div_start = cmd.div_start;
    case (cmd.start_sel)
      nnd_pkg::DIV_TW,
      nnd_pkg::DIV_TH: begin
        div_num = mul_r + NUM_W'(big >> 1);
        div_den = big;
      end
      nnd_pkg::DIV_AX: begin
        div_num = NUM_W'(w);
        div_den = tw_r;
      end
      nnd_pkg::DIV_AY: begin
        div_num = NUM_W'(h);
        div_den = th_r;
      end
      default: begin
        div_num = mul_r;
        div_den = big;
      end
    endcase
  end

  nnd_div #(
    .NUM_W (NUM_W),
    .DEN_W (SIDE_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // Quotients that are kept never exceed a side length
  assign quo_t = div_quo[SIDE_W-1:0];

  // Capture setup results
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      case (cmd.load_sel)
        nnd_pkg::DIV_TW: tw_r <= scale ? ((quo_t == '0) ? SIDE_W'(1) : quo_t) : w;
        nnd_pkg::DIV_TH: th_r <= scale ? ((quo_t == '0) ? SIDE_W'(1) : quo_t) : h;
        nnd_pkg::DIV_AX: begin
          ax_r <= quo_t;
          bx_r <= div_rem;
        end
        nnd_pkg::DIV_AY: begin
          ay_r <= quo_t;
          by_r <= div_rem;
        end
        default: tw_r <= tw_r;
      endcase
    end
  end

  // Pixel evaluation
  always_comb begin
    pix  = cmd.use_held ? hold_r : in_tdata;
    hit  = (or_r < th_r) && (SIDE_W'(sr_r) == row_q_r) && (SIDE_W'(sc_r) == col_q_r);
    emit = cmd.step && hit;
    last = (or_r == th_r - SIDE_W'(1)) && (oc_r == tw_r - SIDE_W'(1));

    // next nearest source position on each axis: add S = a*T + b
    oc_inc = oc_r + SIDE_W'(1);
    csum   = {1'b0, col_r_r} + {1'b0, bx_r};
    cwrap  = csum >= {1'b0, tw_r};
    rsum   = {1'b0, row_r_r} + {1'b0, by_r};
    rwrap  = rsum >= {1'b0, th_r};

    sc_inc = {1'b0, sc_r} + (POS_W+1)'(1);
    sr_inc = {1'b0, sr_r} + (POS_W+1)'(1);

    sc_nxt    = sc_r;
    sr_nxt    = sr_r;
    oc_nxt    = oc_r;
    or_nxt    = or_r;
    col_q_nxt = col_q_r;
    col_r_nxt = col_r_r;
    row_q_nxt = row_q_r;
    row_r_nxt = row_r_r;

    if (cmd.init_pos) begin
      oc_nxt    = '0;
      or_nxt    = '0;
      col_q_nxt = '0;
      col_r_nxt = tw_r >> 1;
      row_q_nxt = '0;
      row_r_nxt = th_r >> 1;
    end

    if (emit) begin
      if (oc_inc >= tw_r) begin
        oc_nxt    = '0;
        or_nxt    = or_r + SIDE_W'(1);
        col_q_nxt = '0;
        col_r_nxt = tw_r >> 1;
        row_q_nxt = row_q_r + ay_r + SIDE_W'(rwrap);
        row_r_nxt = rwrap ? SIDE_W'(rsum - {1'b0, th_r}) : SIDE_W'(rsum);
      end else begin
        oc_nxt    = oc_inc;
        col_q_nxt = col_q_r + ax_r + SIDE_W'(cwrap);
        col_r_nxt = cwrap ? SIDE_W'(csum - {1'b0, tw_r}) : SIDE_W'(csum);
      end
    end

    // Raster position of the incoming pixel
    if (cmd.step) begin
      if (sc_inc >= (POS_W+1)'(w)) begin
        sc_nxt = '0;
        if (sr_inc >= (POS_W+1)'(h)) begin
          sr_nxt = '0;
        end else begin
          sr_nxt = POS_W'(sr_inc);
        end
      end else begin
        sc_nxt = POS_W'(sc_inc);
      end
    end

    if (cfg_hit) begin
      sc_nxt = '0;
      sr_nxt = '0;
    end

    ov_nxt = emit || (ov_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= CFG_W'(1);
      src_height_r <= CFG_W'(1);
      max_dim_r    <= CFG_W'(nnd_pkg::LIMIT_RESET);
      sc_r         <= '0;
      sr_r         <= '0;
      oc_r         <= '0;
      or_r         <= '0;
      ov_r         <= 1'b0;
    end else begin
      src_width_r  <= src_width_nxt;
      src_height_r <= src_height_nxt;
      max_dim_r    <= max_dim_nxt;
      sc_r         <= sc_nxt;
      sr_r         <= sr_nxt;
      oc_r         <= oc_nxt;
      or_r         <= or_nxt;
      ov_r         <= ov_nxt;
    end
    col_q_r <= col_q_nxt;
    col_r_r <= col_r_nxt;
    row_q_r <= row_q_nxt;
    row_r_r <= row_r_nxt;
    if (cmd.hold) begin
      hold_r <= in_tdata;
    end
    if (emit) begin
      od_r <= pix;
      ol_r <= last;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;

  assign status.frame_start = (sc_r == '0) && (sr_r == '0);
  assign status.out_free    = !ov_r || out_tready;
  assign status.div_done    = div_done;

endmodule

`default_nettype wire

### design/nnd_ctrl.sv
`default_nettype none

// Sequencer: pixel acceptance and the frame setup divisions
module nnd_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire nnd_pkg::status_t status,
  output nnd_pkg::cmd_t         cmd
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MULW = 7'b0000010,
    ST_MULH = 7'b0000100,
    ST_DIVW = 7'b0001000,
    ST_DIVH = 7'b0010000,
    ST_DIVX = 7'b0100000,
    ST_DIVY = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   eval_r, eval_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    eval_nxt  = eval_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (eval_r) begin
          // first pixel of the frame, once setup is done
          if (status.out_free) begin
            cmd.step     = 1'b1;
            cmd.use_held = 1'b1;
            eval_nxt     = 1'b0;
          end
        end else begin
          in_tready = status.out_free;
          if (in_tvalid && status.out_free) begin
            cmd.hold = 1'b1;
            if (status.frame_start) begin
              state_nxt = ST_MULW;
            end else begin
              cmd.step = 1'b1;
            end
          end
        end
      end
      ST_MULW: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_MULH;
      end
      ST_MULH: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_h     = 1'b1;
        cmd.div_start = 1'b1;
        cmd.start_sel = nnd_pkg::DIV_TW;
        state_nxt     = ST_DIVW;
      end
      ST_DIVW: begin
        if (status.div_done) begin
          cmd.load      = 1'b1;
          cmd.load_sel  = nnd_pkg::DIV_TW;
          cmd.div_start = 1'b1;
          cmd.start_sel = nnd_pkg::DIV_TH;
          state_nxt     = ST_DIVH;
        end
      end
      ST_DIVH: begin
        if (status.div_done) begin
          cmd.load      = 1'b1;
          cmd.load_sel  = nnd_pkg::DIV_TH;
          cmd.div_start = 1'b1;
          cmd.start_sel = nnd_pkg::DIV_AX;
          state_nxt     = ST_DIVX;
        end
      end
      ST_DIVX: begin
        if (status.div_done) begin
          cmd.load      = 1'b1;
          cmd.load_sel  = nnd_pkg::DIV_AX;
          cmd.div_start = 1'b1;
          cmd.start_sel = nnd_pkg::DIV_AY;
          state_nxt     = ST_DIVY;
        end
      end
      ST_DIVY: begin
        if (status.div_done) begin
          cmd.load     = 1'b1;
          cmd.load_sel = nnd_pkg::DIV_AY;
          cmd.init_pos = 1'b1;
          eval_nxt     = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      eval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      eval_r  <= eval_nxt;
    end
  end

endmodule

`default_nettype wire

### tb/tb_nearest_neighbor_downscale.sv
`default_nettype none

module tb_nearest_neighbor_downscale;

  localparam int SETTLE_CYCLES  = 200;       // covers the frame-start divider
  localparam int RX_HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS   = 1000;
  localparam int TIMEOUT_UNITS  = 10_000_000;

  // Register indexes of the write port
  typedef enum logic [1:0] {
    REG_SRC_W   = 2'd0,
    REG_SRC_H   = 2'd1,
    REG_MAX_DIM = 2'd2,
    REG_SPARE   = 2'd3   // no register behind it
  } reg_idx_t;

  typedef enum logic {
    ROW_CFG = 1'b0,
    ROW_PIX = 1'b1
  } row_kind_t;

  typedef struct packed {
    logic [nnd_pkg::PIX_W-1:0] pixel;
    logic                      last;
  } pix_beat_t;

  // One directed step: a register write or a run of pixels
  typedef struct packed {
    row_kind_t                 kind;
    reg_idx_t                  idx;
    logic [nnd_pkg::CFG_W-1:0] val;
    logic [nnd_pkg::PIX_W-1:0] px;
    logic [7:0]                reps;
    logic                      typed;    // expected beat written out below
    logic                      exp_last;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [19] = '{
    // reset size 1x1: every pixel is a whole frame
    '{ROW_PIX, REG_SRC_W,   15'd0,     32'h0000_0000, 8'd1,  1'b1, 1'b1},
    '{ROW_PIX, REG_SRC_W,   15'd0,     32'hFFFF_FFFF, 8'd1,  1'b1, 1'b1},
    // write to the spare index leaves everything alone
    '{ROW_CFG, REG_SPARE,   15'h7FFF,  32'h0,         8'd0,  1'b0, 1'b0},
    '{ROW_PIX, REG_SRC_W,   15'd0,     32'hA5A5_A5A5, 8'd1,  1'b1, 1'b1},
    // zero sizes and zero limit count as 1
    '{ROW_CFG, REG_SRC_W,   15'd0,     32'h0,         8'd0,  1'b0, 1'b0},
    '{ROW_CFG, REG_SRC_H,   15'd0,     32'h0,         8'd0,  1'b0, 1'b0},
    '{ROW_CFG, REG_MAX_DIM, 15'd0,     32'h0,         8'd0,  1'b0, 1'b0},
    '{ROW_PIX, REG_SRC_W,   15'd0,     32'h5A5A_5A5A, 8'd1,  1'b1, 1'b1},
    // 4x3 down to 2x2, one full frame and the start of the next
    '{ROW_CFG, REG_SRC_W,   15'd4,     32'h0,         8'd0,  1'b0, 1'b0},
    '{ROW_CFG, REG_SRC_H,   15'd3,     32'h0,         8'd0,  1'b0, 1'b0},
    '{ROW_CFG, REG_MAX_DIM, 15'd2,     32'h0,         8'd0,  1'b0, 1'b0},
    '{ROW_PIX, REG_SRC_W,   15'd0,     32'h1020_3040, 8'd13, 1'b0, 1'b0},
    // oversized width clamps, limit 1 gives a 1x1 output
    '{ROW_CFG, REG_SRC_W,   15'h7FFF,  32'h0,         8'd0,  1'b0, 1'b0},
    '{ROW_CFG, REG_SRC_H,   15'd1,     32'h0,         8'd0,  1'b0, 1'b0},
    '{ROW_CFG, REG_MAX_DIM, 15'd1,     32'h0,         8'd0,  1'b0, 1'b0},
    '{ROW_PIX, REG_SRC_W,   15'd0,     32'h0F0F_0F0F, 8'd1,  1'b1, 1'b1},
    // output frame complete: rest of the row is dropped
    '{ROW_PIX, REG_SRC_W,   15'd0,     32'hF0F0_F0F0, 8'd3,  1'b0, 1'b0},
    // limit above the side: pass-through
    '{ROW_CFG, REG_MAX_DIM, 15'h7FFF,  32'h0,         8'd0,  1'b0, 1'b0},
    '{ROW_PIX, REG_SRC_W,   15'd0,     32'h3C3C_3C3C, 8'd3,  1'b0, 1'b0}
  };

  localparam logic [nnd_pkg::CFG_W-1:0] EDGE_VALS [6] = '{
    15'd0, 15'd1, 15'd2, 15'd16383, 15'd16384, 15'h7FFF
  };

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [nnd_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [nnd_pkg::CFG_W-1:0]      cfg_wdata;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [nnd_pkg::PIX_W-1:0]      in_tdata;   // [31:0] in_pixel
  logic                           out_tvalid;
  logic                           out_tready;
  logic [nnd_pkg::PIX_W-1:0]      out_tdata;  // [31:0] out_pixel
  logic                           out_tlast;

  nearest_neighbor_downscale dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // Scaler state as the block should hold it
  bit [nnd_pkg::CFG_W-1:0] reg_w   = 15'd1;
  bit [nnd_pkg::CFG_W-1:0] reg_h   = 15'd1;
  bit [nnd_pkg::CFG_W-1:0] reg_lim = 15'(nnd_pkg::LIMIT_RESET);
  bit [15:0] src_col, src_row, out_col, out_row, want_col, want_row, tgt_w, tgt_h;

  pix_beat_t due_pixels [$];
  int  fail_cnt    = 0;
  int  sent_cnt    = 0;
  int  burst_left  = 0;
  bit  dirty       = 1'b0;  // pixels sent since the last drain
  bit  rx_hold_req = 1'b0;

  function automatic bit [15:0] eff_side(input bit [nnd_pkg::CFG_W-1:0] r);
    if (r == 0) return 16'd1;
    if (r > nnd_pkg::MAX_SOURCE_SIDE) return 16'(nnd_pkg::MAX_SOURCE_SIDE);
    return 16'(r);
  endfunction

  // Source index for output index t on one axis
  function automatic bit [15:0] near_src(input bit [15:0] t, s, tg);
    bit [63:0] p;
    if (tg == 0) return 16'd0;
    p = (64'(t) * 64'(s) + 64'(tg >> 1)) / 64'(tg);
    if (p > 64'(s) - 1) p = 64'(s) - 1;
    return p[15:0];
  endfunction

  // Target side, rounded half up, never below 1
  function automatic bit [15:0] shrink_side(input bit [15:0] s, lim, big);
    bit [63:0] v;
    v = (64'(s) * 64'(lim) + 64'(big >> 1)) / 64'(big);
    if (v < 1) v = 1;
    return v[15:0];
  endfunction

  function automatic void clear_position();
    src_col = 0; src_row = 0; out_col = 0; out_row = 0;
    want_col = 0; want_row = 0; tgt_w = 0; tgt_h = 0;
  endfunction

  function automatic void model_write(input reg_idx_t idx,
                                      input logic [nnd_pkg::CFG_W-1:0] val);
    case (idx)
      REG_SRC_W:   reg_w   = val;
      REG_SRC_H:   reg_h   = val;
      REG_MAX_DIM: reg_lim = val;
      default:     return;
    endcase
    clear_position();
  endfunction

  // Advance by one source pixel; returns 1 when it is selected
  function automatic bit downscale_step(input logic [nnd_pkg::PIX_W-1:0] px,
                                        output pix_beat_t beat);
    bit [15:0] w, h, lim, big;
    bit hit;
    w    = eff_side(reg_w);
    h    = eff_side(reg_h);
    hit  = 1'b0;
    beat = '0;
    if (src_col == 0 && src_row == 0) begin
      lim = (reg_lim == 0) ? 16'd1 : 16'(reg_lim);
      big = (w > h) ? w : h;
      if (big > lim) begin
        tgt_w = shrink_side(w, lim, big);
        tgt_h = shrink_side(h, lim, big);
      end else begin
        tgt_w = w;
        tgt_h = h;
      end
      out_col = 0; out_row = 0; want_col = 0; want_row = 0;
    end
    if (out_row < tgt_h && src_row == want_row && src_col == want_col) begin
      beat.pixel = px;
      beat.last  = (out_row == tgt_h - 1) && (out_col == tgt_w - 1);
      hit = 1'b1;
      out_col++;
      if (out_col >= tgt_w) begin
        out_col  = 0;
        out_row++;
        want_col = 0;
        want_row = near_src(out_row, h, tgt_h);
      end else begin
        want_col = near_src(out_col, w, tgt_w);
      end
    end
    src_col++;
    if (src_col >= w) begin
      src_col = 0;
      src_row++;
      if (src_row >= h) src_row = 0;
    end
    return hit;
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [nnd_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    model_write(idx, val);
    @(posedge clk);
  endtask

  // Offer one pixel; bursts and gaps are decided here
  task automatic send_pixel(input logic [nnd_pkg::PIX_W-1:0] px,
                            input bit typed, input bit exp_last);
    pix_beat_t beat;
    bit        hit;
    int        gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
    hit = downscale_step(px, beat);
    if (typed) begin
      hit  = 1'b1;
      beat = '{pixel: px, last: exp_last};
    end
    if (hit) due_pixels.insert(due_pixels.size(), beat);
    sent_cnt++;
    dirty = 1'b1;
  endtask

  // Stop offering, let every expected beat come out, then let the block settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (due_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    dirty = 1'b0;
  endtask

  task automatic random_phase(input bit first);
    logic [nnd_pkg::CFG_W-1:0] w, h, lim;
    bit [15:0] fw, fh;
    int npx, pause_at, s;
    if (first) begin
      // plain pass-through, long enough for the receiver hold to back up the input
      w = 15'd8; h = 15'd6; lim = 15'(nnd_pkg::LIMIT_RESET);
      npx = 3 * 48;
    end else begin
      case ($urandom_range(0, 9))
        0: begin
          // one huge side, partial frame only
          w   = 15'($urandom_range(1, 32767));
          h   = 15'($urandom_range(1, 4));
          if ($urandom_range(0, 1) == 1) {w, h} = {h, w};
          lim = 15'($urandom());
          npx = $urandom_range(40, 120);
        end
        1: begin
          w   = EDGE_VALS[$urandom_range(0, 5)];
          h   = EDGE_VALS[$urandom_range(0, 5)];
          lim = EDGE_VALS[$urandom_range(0, 5)];
          npx = $urandom_range(20, 60);
        end
        default: begin
          // small frames, mostly downscaled, sent whole with a partial tail
          w   = 15'($urandom_range(0, 12));
          h   = 15'($urandom_range(0, 12));
          lim = 15'($urandom_range(0, 16));
          fw  = eff_side(w);
          fh  = eff_side(h);
          npx = int'(fw) * int'(fh) * $urandom_range(1, 3) + $urandom_range(0, fw);
        end
      endcase
    end
    pause_at = (first || $urandom_range(0, 3) == 0) ? npx / 2 : -1;

    if (dirty) wait_idle();
    s = $urandom_range(0, 2);
    for (int j = 0; j < 3; j++) begin
      case (reg_idx_t'((s + j) % 3))
        REG_SRC_W: write_reg(REG_SRC_W, w);
        REG_SRC_H: write_reg(REG_SRC_H, h);
        default:   write_reg(REG_MAX_DIM, lim);
      endcase
    end
    if ($urandom_range(0, 4) == 0) write_reg(REG_SPARE, 15'($urandom()));

    if (first) rx_hold_req = 1'b1;
    for (int k = 0; k < npx; k++) begin
      // mid-frame drain; a spare-index write here must keep the position
      if (k == pause_at) begin
        wait_idle();
        if (first || $urandom_range(0, 1) == 1) write_reg(REG_SPARE, 15'($urandom()));
      end
      send_pixel($urandom(), 1'b0, 1'b0);
    end
  endtask

  // Receiver: check each beat, stall in changing modes
  initial begin : rx_side
    pix_beat_t want;
    int mode, mode_left, hold_left, cyc;
    out_tready = 1'b0;
    mode = 0; mode_left = 0; hold_left = 0; cyc = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid === 1'b1 && out_tready) begin
        if (due_pixels.size() == 0) begin
          $error("out beat with nothing expected: out_pixel=%h out_last=%b",
                 out_tdata, out_tlast);
          fail_cnt++;
        end else begin
          want = due_pixels.pop_front();
          if (out_tdata !== want.pixel) begin
            $error("out_pixel: expected %h, got %h", want.pixel, out_tdata);
            fail_cnt++;
          end
          if (out_tlast !== want.last) begin
            $error("out_last: expected %b, got %b", want.last, out_tlast);
            fail_cnt++;
          end
        end
      end
      if (rx_hold_req) begin
        hold_left   = RX_HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(32, 200);
      end
      mode_left--;
      cyc++;
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 3) != 0);
          2:       out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= (cyc % 3 == 0);
        endcase
      end
    end
  end

  // Stimulus
  initial begin : stim
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    clear_position();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    foreach (DIR_TAB[i]) begin
      if (DIR_TAB[i].kind == ROW_CFG) begin
        if (dirty) wait_idle();
        write_reg(DIR_TAB[i].idx, DIR_TAB[i].val);
      end else begin
        for (int k = 0; k < DIR_TAB[i].reps; k++)
          send_pixel(DIR_TAB[i].px + 32'(k) * 32'h1111_1111,
                     DIR_TAB[i].typed, DIR_TAB[i].exp_last);
      end
    end

    // Random phases
    random_phase(1'b1);
    while (sent_cnt < RANDOM_ITEMS) random_phase(1'b0);

    wait_idle();
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hang guard
  initial begin : watchdog
    #(TIMEOUT_UNITS);
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
+incdir+design
design/nnd_pkg.sv
design/nnd_div.sv
design/nnd_datapath.sv
design/nnd_ctrl.sv
design/nearest_neighbor_downscale.sv
tb/tb_nearest_neighbor_downscale.sv
